// ===== sv/rgbblend_pkg.sv =====
// shared types, register codes and helpers for the rgba to rgb565 blit/blend stage
`timescale 1ns / 1ps
`default_nettype none
package rgbblend_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_ROP_MODE    = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_X    = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Y    = 3'd2;
   localparam logic [2:0] CSR_X_MIN       = 3'd3;
   localparam logic [2:0] CSR_Y_MIN       = 3'd4;
   localparam logic [2:0] CSR_X_END       = 3'd5;
   localparam logic [2:0] CSR_Y_END       = 3'd6;
   localparam logic [2:0] CSR_DEST_WIDTH  = 3'd7;

   // raster operation codes (the spare code acts as copy)
   localparam logic [1:0] ROP_COPY  = 2'd0;
   localparam logic [1:0] ROP_KEY   = 2'd1;
   localparam logic [1:0] ROP_BLEND = 2'd2;

   // widths
   localparam int COORD_W = 13;
   localparam int INDEX_W = 24;
   localparam int PIXEL_W = 16;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 40;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // configuration registers as a group
   typedef struct packed {
      logic [1:0]         rop_mode;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [COORD_W-1:0] x_min;
      logic [COORD_W-1:0] y_min;
      logic [COORD_W-1:0] x_end;
      logic [COORD_W-1:0] y_end;
      logic [COORD_W-1:0] dest_width;
   } cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      logic               write;
      logic               blend;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [PIXEL_W-1:0] dest;
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
   } item_type;

   // exact floor(x / 255) for any x up to 255 * 255, the largest blend sum
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
   endfunction

   // truncating rgb888 to rgb565 pack
   function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage
`default_nettype wire

// ===== sv/rgba_to_rgb565_blit_blend.sv =====
// top level of the rgba8888 to rgb565 blit/blend compose stage
`timescale 1ns / 1ps
`default_nettype none
// Composes one RGBA8888 source pixel per word into an RGB565 destination.
// Each request word gives one response word: a write flag, the destination
// pixel index (row * dest_width + column, 24 bits) and the new 565 value;
// index and value are zero when the flag is low (outside clip, alpha zero or
// colour-keyed magenta). The block takes one word per clock while its queue
// is not full. A word entering an empty block is written into the classify
// queue on acceptance, then the channel multiplier products are registered and
// then the divide/pack result is loaded into the response register. The front
// keeps accepting while fewer than four classified words wait in the queue, so
// response stalls reach the request side only when that queue is full.
// Configuration writes are always accepted and must be made while idle.
module rgba_to_rgb565_blit_blend (
   input  wire                             clock,
   input  wire                             reset,
   // request: rect_x [11:0], rect_y [23:12], src_rgba [55:24], dest_pixel [71:56]
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire [rgbblend_pkg::REQ_W-1:0]   req_tdata,
   // response: pixel_index [23:0], pixel_out [39:24]
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [rgbblend_pkg::RSP_W-1:0]  rsp_tdata,
   // response: write_enable [0]
   output logic                            rsp_tuser,
   // register write channel
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [2:0]                       csr_index,
   input  wire [15:0]                      csr_data
);
   import rgbblend_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     queue_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     head_valid;
   item_type head_item;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROP_MODE:   cfg_in.rop_mode   = csr_data[1:0];
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_data;
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_data;
            CSR_X_MIN:      cfg_in.x_min      = csr_data[COORD_W-1:0];
            CSR_Y_MIN:      cfg_in.y_min      = csr_data[COORD_W-1:0];
            CSR_X_END:      cfg_in.x_end      = csr_data[COORD_W-1:0];
            CSR_Y_END:      cfg_in.y_end      = csr_data[COORD_W-1:0];
            CSR_DEST_WIDTH: cfg_in.dest_width = csr_data[COORD_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rop_mode   <= ROP_COPY;
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.x_min      <= '0;
         cfg_ff.y_min      <= '0;
         cfg_ff.x_end      <= COORD_W'(4096);
         cfg_ff.y_end      <= COORD_W'(4096);
         cfg_ff.dest_width <= COORD_W'(4096);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify
   rgbblend_front u_front (
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // decoupling queue
   rgbblend_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (head_valid),
      .head_item (head_item)
   );

   // compose and deliver
   rgbblend_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== sv/rgbblend_front.sv =====
// front end: places the pixel, clips it and classifies the write
`timescale 1ns / 1ps
`default_nettype none
module rgbblend_front (
   input  wire rgbblend_pkg::cfg_type  cfg,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire [rgbblend_pkg::REQ_W-1:0] req_tdata,
   input  wire                         queue_full,
   output logic                        push,
   output rgbblend_pkg::item_type      push_item
);
   import rgbblend_pkg::*;

   logic [11:0]        rect_x;
   logic [11:0]        rect_y;
   logic [31:0]        src_rgba;
   logic [15:0]        dest_pixel;
   logic signed [16:0] dx;
   logic signed [16:0] dy;
   logic               in_window;
   logic               keyed;
   logic               opaque_zero;

   // unpack the request word
   assign rect_x     = req_tdata[11:0];
   assign rect_y     = req_tdata[23:12];
   assign src_rgba   = req_tdata[55:24];
   assign dest_pixel = req_tdata[71:56];

   // destination position
   assign dx = 17'(cfg.origin_x) + $signed({5'd0, rect_x});
   assign dy = 17'(cfg.origin_y) + $signed({5'd0, rect_y});

   // clip test against the half-open rectangle
   assign in_window = (dx >= $signed({4'd0, cfg.x_min})) &&
                      (dx <  $signed({4'd0, cfg.x_end})) &&
                      (dy >= $signed({4'd0, cfg.y_min})) &&
                      (dy <  $signed({4'd0, cfg.y_end}));

   // transparency tests
   assign keyed = (cfg.rop_mode == ROP_KEY) && (src_rgba[31:24] == 8'hff) &&
                  (src_rgba[23:16] == 8'h00) && (src_rgba[15:8] == 8'hff);
   assign opaque_zero = (src_rgba[7:0] == 8'h00);

   // handshake into the queue
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // classified word
   always_comb begin
      push_item.write = in_window && !opaque_zero && !keyed;
      push_item.blend = (cfg.rop_mode == ROP_BLEND) && (src_rgba[7:0] != 8'hff);
      push_item.red   = src_rgba[31:24];
      push_item.green = src_rgba[23:16];
      push_item.blue  = src_rgba[15:8];
      push_item.alpha = src_rgba[7:0];
      push_item.dest  = dest_pixel;
      push_item.dx    = dx[COORD_W-1:0];
      push_item.dy    = dy[COORD_W-1:0];
   end

endmodule
`default_nettype wire

// ===== sv/rgbblend_queue.sv =====
// short queue of classified words between front and back
`timescale 1ns / 1ps
`default_nettype none
module rgbblend_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire rgbblend_pkg::item_type push_item,
   output logic                       full,
   input  wire                        pop,
   output logic                       not_empty,
   output rgbblend_pkg::item_type     head_item
);
   import rgbblend_pkg::*;

   item_type            store_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff;
   logic [QUEUE_AW:0]   count_in;
   logic                do_pop;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign head_item = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rgbblend_back.sv =====
// back end: channel mix, pack and index, two stages ending in the result register
`timescale 1ns / 1ps
`default_nettype none
module rgbblend_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire rgbblend_pkg::cfg_type   cfg,
   input  wire                          head_valid,
   input  wire rgbblend_pkg::item_type  head_item,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic                         rsp_tuser,
   output logic [rgbblend_pkg::RSP_W-1:0] rsp_tdata
);
   import rgbblend_pkg::*;

   logic                   advance;
   logic [7:0]             inv_alpha;
   logic [7:0]             dest_r;
   logic [7:0]             dest_g;
   logic [7:0]             dest_b;

   // product stage
   logic                   a_vld_ff;
   logic                   a_write_ff;
   logic                   a_blend_ff;
   logic [15:0]            a_src_pack_ff;
   logic [15:0]            a_sr_ff;
   logic [15:0]            a_sg_ff;
   logic [15:0]            a_sb_ff;
   logic [15:0]            a_dr_ff;
   logic [15:0]            a_dg_ff;
   logic [15:0]            a_db_ff;
   logic [2*COORD_W-1:0]   a_row_ff;
   logic [COORD_W-1:0]     a_dx_ff;

   // result stage
   logic                   out_vld_ff;
   logic                   out_write_ff;
   logic [INDEX_W-1:0]     out_index_ff;
   logic [PIXEL_W-1:0]     out_pixel_ff;

   logic [16:0]            sum_r;
   logic [16:0]            sum_g;
   logic [16:0]            sum_b;
   logic [PIXEL_W-1:0]     pixel_in;
   logic [INDEX_W-1:0]     index_in;

   // the whole back end moves when the result register can be refilled
   assign advance = !out_vld_ff || rsp_tready;
   assign pop     = advance && head_valid;

   // destination unpack by plain shift
   assign inv_alpha = 8'hff - head_item.alpha;
   assign dest_r    = {head_item.dest[15:11], 3'b000};
   assign dest_g    = {head_item.dest[10:5], 2'b00};
   assign dest_b    = {head_item.dest[4:0], 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= head_valid;
      end
   end

   // channel and row products
   always_ff @(posedge clock) begin
      if (pop) begin
         a_write_ff    <= head_item.write;
         a_blend_ff    <= head_item.blend;
         a_src_pack_ff <= pack565(head_item.red, head_item.green, head_item.blue);
         a_sr_ff       <= head_item.red * head_item.alpha;
         a_sg_ff       <= head_item.green * head_item.alpha;
         a_sb_ff       <= head_item.blue * head_item.alpha;
         a_dr_ff       <= dest_r * inv_alpha;
         a_dg_ff       <= dest_g * inv_alpha;
         a_db_ff       <= dest_b * inv_alpha;
         a_row_ff      <= head_item.dy * cfg.dest_width;
         a_dx_ff       <= head_item.dx;
      end
   end

   // sums, divide by 255, pack and index
   always_comb begin
      sum_r    = {1'b0, a_sr_ff} + {1'b0, a_dr_ff};
      sum_g    = {1'b0, a_sg_ff} + {1'b0, a_dg_ff};
      sum_b    = {1'b0, a_sb_ff} + {1'b0, a_db_ff};
      pixel_in = a_blend_ff ?
                 pack565(div255(sum_r[15:0]), div255(sum_g[15:0]), div255(sum_b[15:0])) :
                 a_src_pack_ff;
      index_in = a_row_ff[INDEX_W-1:0] + {{(INDEX_W-COORD_W){1'b0}}, a_dx_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= a_vld_ff;
      end
   end

   // result register, fields forced to zero when nothing is written
   always_ff @(posedge clock) begin
      if (advance && a_vld_ff) begin
         out_write_ff <= a_write_ff;
         out_index_ff <= a_write_ff ? index_in : '0;
         out_pixel_ff <= a_write_ff ? pixel_in : '0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_write_ff;
   assign rsp_tdata  = {out_pixel_ff, out_index_ff};

endmodule
`default_nettype wire
